// ----- hw/rtl/masked_and_gadget_assert.svh -----
// Assertion macros for the masked AND gadget port checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef MASKED_AND_GADGET_ASSERT_SVH
`define MASKED_AND_GADGET_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MAG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("masked_and_gadget: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define MAG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("masked_and_gadget: next-cycle check failed");

`endif

// ----- hw/rtl/mag_pkg.sv -----
// Package for the masked AND gadget: field widths and constants.
// No dependencies.
package mag_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned FIELD_BYTES    = 3;
    localparam int unsigned FIELD_BITS     = BYTE_W * FIELD_BYTES;
    localparam int unsigned SHARES_DEFAULT = 3;

    // Random byte masks: upper nibble only, or the whole byte
    localparam logic [BYTE_W-1:0] NIBBLE_KEEP = 8'hf0;
    localparam logic [BYTE_W-1:0] FULL_KEEP   = 8'hff;

    typedef logic [FIELD_BITS-1:0] field_t;

endpackage

// ----- hw/rtl/masked_and_gadget.sv -----
// Top level of the ISW-style Boolean-masked AND gadget, bitsliced bytes.
// Depends on mag_pkg.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  item     | item_valid / item_stall      | x_shares, y_shares, random_bytes
//  result   | result_valid / result_stall  | z_shares
//  config   | cfg_write_en (no wait)       | cfg_write_data (half_width_mode)
//
// An item taken on the item channel enters the item register, then passes
// through the gadget logic into the result register, raising result_valid.
// One transaction per clock is sustained while result_stall is low; a single
// pass of AND/XOR logic lies between the two registers.
// Reset (rst_n low, asynchronous) empties both stages and clears
// half_width_mode. A result stall holds the result register; the item
// register still fills, so item_stall rises only once both stages are full.
module masked_and_gadget #(
    parameter int unsigned SHARES = mag_pkg::SHARES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    // configuration
    input  logic           cfg_write_en,
    input  logic           cfg_write_data,
    // item channel
    input  logic           item_valid,
    output logic           item_stall,
    input  mag_pkg::field_t x_shares,
    input  mag_pkg::field_t y_shares,
    input  mag_pkg::field_t random_bytes,
    // result channel
    output logic           result_valid,
    input  logic           result_stall,
    output mag_pkg::field_t z_shares
);

    localparam int unsigned BW        = mag_pkg::BYTE_W;
    localparam int unsigned PAIRS     = SHARES * (SHARES - 1) / 2;
    localparam int unsigned MAX_SP    = (SHARES > PAIRS) ? SHARES : PAIRS;
    // Padded working width: bytes beyond a field read as zero
    localparam int unsigned PAD_BYTES =
        (MAX_SP > mag_pkg::FIELD_BYTES) ? MAX_SP : mag_pkg::FIELD_BYTES;
    localparam int unsigned PAD_BITS  = BW * PAD_BYTES;

    logic            half_width_mode_reg;
    logic            item_valid_reg, item_valid_next;
    logic            result_valid_reg, result_valid_next;
    mag_pkg::field_t x_reg, y_reg, r_reg;
    mag_pkg::field_t z_reg, z_next;

    logic            result_adv;   // result register may load
    logic            item_adv;     // item register may load

    logic [PAD_BITS-1:0] x_pad, y_pad, r_pad, z_pad;
    logic [BW-1:0]       r_keep;

    // ------------------------------------------------------------------
    // Handshake: two-stage pipeline, each stage loads when it is empty or
    // its contents move on in the same cycle.
    // ------------------------------------------------------------------
    assign result_adv = !result_valid_reg || !result_stall;
    assign item_adv   = !item_valid_reg || result_adv;
    assign item_stall = !item_adv;

    assign item_valid_next   = item_adv ? item_valid : item_valid_reg;
    assign result_valid_next = result_adv ? item_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_mode_reg <= 1'b0;
            item_valid_reg      <= 1'b0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                half_width_mode_reg <= cfg_write_data;
            end
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_adv && item_valid)
        begin
            x_reg <= x_shares;
            y_reg <= y_shares;
            r_reg <= random_bytes;
        end
        if (result_adv && item_valid_reg)
        begin
            z_reg <= z_next;
        end
    end

    // ------------------------------------------------------------------
    // Gadget: z_i = x_i&y_i ^ sum over pairs of r_ij ^ cross products.
    // Pairs (i,j), i<j, take random bytes in i-outer, j-inner order; r_ij
    // goes into z_i with the cross terms and alone into z_j.
    // ------------------------------------------------------------------
    assign r_keep = half_width_mode_reg ? mag_pkg::NIBBLE_KEEP : mag_pkg::FULL_KEEP;

    always_comb
    begin
        int unsigned   p;
        logic [BW-1:0] rb;
        x_pad = PAD_BITS'(x_reg);
        y_pad = PAD_BITS'(y_reg);
        r_pad = PAD_BITS'(r_reg);
        z_pad = '0;
        p     = 0;
        rb    = '0;
        for (int unsigned i = 0; i < SHARES; i++)
        begin
            z_pad[BW*i +: BW] = x_pad[BW*i +: BW] & y_pad[BW*i +: BW];
        end
        for (int unsigned i = 0; i < SHARES; i++)
        begin
            for (int unsigned j = i + 1; j < SHARES; j++)
            begin
                rb = r_pad[BW*p +: BW] & r_keep;
                z_pad[BW*i +: BW] = z_pad[BW*i +: BW] ^ rb
                                  ^ (x_pad[BW*i +: BW] & y_pad[BW*j +: BW])
                                  ^ (x_pad[BW*j +: BW] & y_pad[BW*i +: BW]);
                z_pad[BW*j +: BW] = z_pad[BW*j +: BW] ^ rb;
                p = p + 1;
            end
        end
        // shares beyond the field are dropped
        z_next = z_pad[mag_pkg::FIELD_BITS-1:0];
    end

    assign result_valid = result_valid_reg;
    assign z_shares     = z_reg;

endmodule

// ----- hw/rtl/mag_checker.sv -----
// Port-level checker for masked_and_gadget, attached by bind.
// Depends on mag_pkg and masked_and_gadget_assert.svh.
`include "masked_and_gadget_assert.svh"

module mag_sva_checker #(
    parameter int unsigned SHARES = mag_pkg::SHARES_DEFAULT
) (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input mag_pkg::field_t x_shares,
    input mag_pkg::field_t y_shares,
    input logic            result_valid,
    input logic            result_stall,
    input mag_pkg::field_t z_shares
);

    localparam int unsigned BW = mag_pkg::BYTE_W;

    logic          x_acc_ok;
    logic          item_acc;
    logic          result_free;
    logic [BW-1:0] z_sum, x_sum, y_sum, xy_and;

    assign x_acc_ok    = (SHARES == mag_pkg::FIELD_BYTES);
    assign item_acc    = item_valid && !item_stall;
    assign result_free = !result_valid || !result_stall;
    assign z_sum  = z_shares[0 +: BW] ^ z_shares[BW +: BW] ^ z_shares[2*BW +: BW];
    assign x_sum  = x_shares[0 +: BW] ^ x_shares[BW +: BW] ^ x_shares[2*BW +: BW];
    assign y_sum  = y_shares[0 +: BW] ^ y_shares[BW +: BW] ^ y_shares[2*BW +: BW];
    assign xy_and = x_sum & y_sum;

    // stalled result transaction holds
    `MAG_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid)
    `MAG_ASSERT_NXT(a_result_stable, result_valid && result_stall, $stable(z_shares))

    // upstream back-pressure only when the result stage is full and blocked
    `MAG_ASSERT_IMP(a_stall_cause, item_stall, result_valid && result_stall)

    // an accepted item that then finds the result stage free reaches the result
    // register; when SHARES equals FIELD_BYTES, its shares recombine to the unmasked AND
    `MAG_ASSERT_NXT(a_latency, item_acc ##1 result_free, result_valid)
    `MAG_ASSERT_NXT(a_recombine, x_acc_ok && item_acc ##1 result_free, z_sum == $past(xy_and, 2))

endmodule

bind masked_and_gadget mag_sva_checker #(.SHARES(SHARES)) u_mag_checker (.*);

// ----- tb/sv/mag_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for masked_and_gadget: watches the item, result and config ports.
// Predicts z_shares per accepted item. Depends on mag_pkg.
module mag_checker #(
    parameter int unsigned SHARES = mag_pkg::SHARES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic            cfg_write_data,
    input  logic            item_valid,
    input  logic            item_stall,
    input  mag_pkg::field_t x_shares,
    input  mag_pkg::field_t y_shares,
    input  mag_pkg::field_t random_bytes,
    input  logic            result_valid,
    input  logic            result_stall,
    input  mag_pkg::field_t z_shares,
    output int              mismatches,
    output int              pending
);

    localparam int unsigned BW = mag_pkg::BYTE_W;

    logic            nibble_mode;
    mag_pkg::field_t expected_z[$];

    // ISW gadget model; bytes past the 24-bit field read as zero and are dropped
    function automatic mag_pkg::field_t masked_and_z(mag_pkg::field_t x,
                                                     mag_pkg::field_t y,
                                                     mag_pkg::field_t r,
                                                     logic nibble);
        logic [BW-1:0]   xs[SHARES];
        logic [BW-1:0]   ys[SHARES];
        logic [BW-1:0]   zs[SHARES];
        logic [BW-1:0]   rb;
        int unsigned     p;
        mag_pkg::field_t z;
        p = 0;
        z = '0;
        for (int i = 0; i < SHARES; i++)
        begin
            xs[i] = (i < mag_pkg::FIELD_BYTES) ? x[BW*i +: BW] : '0;
            ys[i] = (i < mag_pkg::FIELD_BYTES) ? y[BW*i +: BW] : '0;
            zs[i] = xs[i] & ys[i];
        end
        for (int i = 0; i < SHARES; i++)
        begin
            for (int j = i + 1; j < SHARES; j++)
            begin
                rb = (p < mag_pkg::FIELD_BYTES) ? r[BW*p +: BW] : '0;
                rb = rb & (nibble ? mag_pkg::NIBBLE_KEEP : mag_pkg::FULL_KEEP);
                zs[i] = zs[i] ^ rb ^ (xs[i] & ys[j]) ^ (xs[j] & ys[i]);
                zs[j] = zs[j] ^ rb;
                p++;
            end
        end
        for (int i = 0; i < SHARES && i < mag_pkg::FIELD_BYTES; i++)
            z[BW*i +: BW] = zs[i];
        return z;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_mode = 1'b0;
            expected_z.delete();
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            // result side first, so a same-edge item can never pair with itself
            if (result_valid && !result_stall)
            begin
                if (expected_z.size() == 0)
                begin
                    $error("z_shares: expected none, actual %06h", z_shares);
                    mismatches++;
                end
                else if (expected_z[0] !== z_shares)
                begin
                    $error("z_shares: expected %06h, actual %06h", expected_z[0], z_shares);
                    mismatches++;
                    void'(expected_z.pop_front());
                end
                else
                    void'(expected_z.pop_front());
            end
            if (item_valid && !item_stall)
                expected_z.push_back(masked_and_z(x_shares, y_shares, random_bytes,
                                                  nibble_mode));
            if (cfg_write_en)
                nibble_mode = cfg_write_data;
            pending = expected_z.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Top of the masked_and_gadget testbench: clock, reset, stimulus and verdict.
// Depends on mag_pkg, masked_and_gadget and mag_checker.
module tb;

    localparam int unsigned SHARES      = mag_pkg::SHARES_DEFAULT;
    localparam int unsigned BW          = mag_pkg::BYTE_W;
    localparam int          DIR_COUNT   = 12;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 200;
    localparam int          DRAIN_LIMIT = 5000;

    // Directed transactions, run once per mode. Covers all-zero and all-one
    // fields, each operand alone, random bytes that the nibble mask keeps
    // entirely or removes entirely, alternating patterns and single bits at
    // the ends of the fields.
    localparam mag_pkg::field_t DIR_X [DIR_COUNT] = '{
        24'h000000, 24'hffffff, 24'hffffff, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'haaaaaa, 24'h555555, 24'h000001, 24'hff00ff, 24'h0000ff};
    localparam mag_pkg::field_t DIR_Y [DIR_COUNT] = '{
        24'h000000, 24'hffffff, 24'h000000, 24'hffffff, 24'h000000, 24'h000000,
        24'h000000, 24'h555555, 24'haaaaaa, 24'h800000, 24'h00ff00, 24'hff0000};
    localparam mag_pkg::field_t DIR_R [DIR_COUNT] = '{
        24'h000000, 24'hffffff, 24'h000000, 24'h000000, 24'hffffff, 24'h0f0f0f,
        24'hf0f0f0, 24'h123456, 24'ha5c3e1, 24'h800001, 24'hff0000, 24'h00ff00};

    logic            clk            = 1'b0;
    logic            rst_n          = 1'b0;
    logic            cfg_write_en   = 1'b0;
    logic            cfg_write_data = 1'b0;
    logic            item_valid     = 1'b0;
    logic            item_stall;
    mag_pkg::field_t x_shares       = '0;
    mag_pkg::field_t y_shares       = '0;
    mag_pkg::field_t random_bytes   = '0;
    logic            result_valid;
    logic            result_stall   = 1'b0;
    mag_pkg::field_t z_shares;

    int              mismatches;
    int              pending;
    logic            idle_on        = 1'b1;  // enables random gaps and stalls on both sides
    logic            drain_stuck    = 1'b0;  // results still owed when a drain gave up
    int              hold_left      = 0;

    masked_and_gadget #(.SHARES(SHARES)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .x_shares       (x_shares),
        .y_shares       (y_shares),
        .random_bytes   (random_bytes),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .z_shares       (z_shares)
    );

    mag_checker #(.SHARES(SHARES)) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .x_shares       (x_shares),
        .y_shares       (y_shares),
        .random_bytes   (random_bytes),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .z_shares       (z_shares),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop; a correct run finishes in well under a tenth of this
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result back-pressure: stall bursts of random length, started only while idling is on
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 6) == 0)
        begin
            hold_left    <= $urandom_range(0, 11);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Mostly uniform bytes; now and then each byte picked from 00, ff or random
    function automatic mag_pkg::field_t pick_field();
        mag_pkg::field_t f;
        f = mag_pkg::field_t'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            for (int b = 0; b < mag_pkg::FIELD_BYTES; b++)
            begin
                case ($urandom_range(0, 2))
                    0:       f[BW*b +: BW] = '0;
                    1:       f[BW*b +: BW] = '1;
                    default: ;
                endcase
            end
        end
        return f;
    endfunction

    // Called at a rising edge. While idling is on, valid now and then drops for a
    // burst of random length, with junk on the payload lines, which the block must ignore.
    task automatic item_gap();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid   <= 1'b0;
            x_shares     <= pick_field();
            y_shares     <= pick_field();
            random_bytes <= pick_field();
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Present one transaction and hold it until the edge that accepts it
    task automatic send_item(mag_pkg::field_t x, mag_pkg::field_t y, mag_pkg::field_t r);
        item_valid   <= 1'b1;
        x_shares     <= x;
        y_shares     <= y;
        random_bytes <= r;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    // Stop sending, wait for every owed result, then idle before returning.
    // Pending is first read after the wait that follows dropping valid, so it already holds the last accepted item.
    task automatic drain();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending != 0)
            drain_stuck = 1'b1;
        repeat (4) @(posedge clk);
    endtask

    // Only ever called with the block drained
    task automatic write_mode(logic half);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= half;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin
        logic half;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, full bytes then nibble rows
        for (int m = 0; m < 2; m++)
        begin
            write_mode(m[0]);
            for (int k = 0; k < DIR_COUNT; k++)
            begin
                item_gap();
                send_item(DIR_X[k], DIR_Y[k], DIR_R[k]);
            end
            drain();
        end

        // Random phases; the first two force each mode, the last runs flat out
        for (int ph = 0; ph < PHASES; ph++)
        begin
            half = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
            write_mode(half);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 50 == 0)
                    idle_on <= (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
                item_gap();
                send_item(pick_field(), pick_field(), pick_field());
            end
            drain();
        end

        if (mismatches == 0 && !drain_stuck)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- masked_and_gadget.f -----
+incdir+hw/rtl
hw/rtl/mag_pkg.sv
hw/rtl/masked_and_gadget.sv
hw/rtl/mag_checker.sv
tb/sv/mag_checker.sv
tb/sv/tb.sv
